@@ sv/dsw_pkg.sv @@
// Shared widths, control word layout and microcode program of the dice sum way counter.
`timescale 1ns / 1ps
package dsw_pkg;

  localparam int FACES_W  = 7;
  localparam int DICE_W   = 7;
  localparam int TARGET_W = 13;
  localparam int WAYS_W   = 32;
  localparam int PROD_W   = FACES_W + DICE_W;

  localparam int MAX_FACES_DEF   = 64;
  localparam int MAX_DICE_DEF    = 64;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  // Program steps
  localparam step_t S_WAIT   = 4'd0;
  localparam step_t S_PROD   = 4'd1;
  localparam step_t S_CHECK  = 4'd2;
  localparam step_t S_INIT   = 4'd3;
  localparam step_t S_ROW    = 4'd4;
  localparam step_t S_CELL   = 4'd5;
  localparam step_t S_ROWEND = 4'd6;
  localparam step_t S_FINAL  = 4'd7;
  localparam step_t S_FINLD  = 4'd8;
  localparam step_t S_SHORT  = 4'd9;

  // Jump conditions
  typedef enum logic [2:0] {
    C_NONE,
    C_IN_FIRE,
    C_SHORT,
    C_IDX_NE_TGT,
    C_ROWS_ZERO,
    C_IDX_NE_LAST,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    logic in_rdy;
    logic prod_ld;
    logic idx_one;
    logic rows_ld;
    logic init_wr;
    logic idx_inc;
    logic idx_clr;
    logic win_clr;
    logic rd_cell;
    logic bank_flip;
    logic rows_dec;
    logic rd_tgt;
    logic out_ld;
    logic out_src_mem;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic short_cut;
    logic idx_ne_tgt;
    logic idx_ne_last;
    logic rows_zero;
    logic out_busy;
  } sts_t;

  typedef struct packed {
    ctl_t  ctl;
    cond_t cond;
    step_t jmp;
    step_t nxt;
  } uword_t;

  // Control store: taken condition goes to jmp, otherwise to nxt.
  function automatic uword_t ucode_rom(input step_t step);
    uword_t w;
    w      = '0;
    w.cond = C_NONE;
    w.jmp  = S_WAIT;
    w.nxt  = S_WAIT;
    case (step)
      S_WAIT: begin
        w.ctl.in_rdy = 1'b1;
        w.cond       = C_IN_FIRE;
        w.jmp        = S_PROD;
        w.nxt        = S_WAIT;
      end
      S_PROD: begin
        w.ctl.prod_ld = 1'b1;
        w.nxt         = S_CHECK;
      end
      S_CHECK: begin
        w.ctl.idx_one = 1'b1;
        w.ctl.rows_ld = 1'b1;
        w.cond        = C_SHORT;
        w.jmp         = S_SHORT;
        w.nxt         = S_INIT;
      end
      S_INIT: begin
        w.ctl.init_wr = 1'b1;
        w.ctl.idx_inc = 1'b1;
        w.cond        = C_IDX_NE_TGT;
        w.jmp         = S_INIT;
        w.nxt         = S_ROW;
      end
      S_ROW: begin
        w.ctl.idx_clr = 1'b1;
        w.ctl.win_clr = 1'b1;
        w.cond        = C_ROWS_ZERO;
        w.jmp         = S_FINAL;
        w.nxt         = S_CELL;
      end
      S_CELL: begin
        w.ctl.rd_cell = 1'b1;
        w.ctl.idx_inc = 1'b1;
        w.cond        = C_IDX_NE_LAST;
        w.jmp         = S_CELL;
        w.nxt         = S_ROWEND;
      end
      S_ROWEND: begin
        w.ctl.bank_flip = 1'b1;
        w.ctl.rows_dec  = 1'b1;
        w.nxt           = S_ROW;
      end
      S_FINAL: begin
        w.ctl.rd_tgt = 1'b1;
        w.nxt        = S_FINLD;
      end
      S_FINLD: begin
        w.ctl.out_ld      = 1'b1;
        w.ctl.out_src_mem = 1'b1;
        w.cond            = C_OUT_BUSY;
        w.jmp             = S_FINLD;
        w.nxt             = S_WAIT;
      end
      S_SHORT: begin
        w.ctl.out_ld = 1'b1;
        w.cond       = C_OUT_BUSY;
        w.jmp        = S_SHORT;
        w.nxt        = S_WAIT;
      end
      default: begin
        w.nxt = S_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

@@ sv/dsw_in_if.sv @@
// Input channel: valid/ready handshake carrying faces, dice and target.
`timescale 1ns / 1ps
interface dsw_in_if;
  import dsw_pkg::*;
  logic                valid;
  logic                ready;
  logic [FACES_W-1:0]  faces;
  logic [DICE_W-1:0]   dice;
  logic [TARGET_W-1:0] target;

  modport source (output valid, output faces, output dice, output target, input ready);
  modport sink (input valid, input faces, input dice, input target, output ready);
endinterface

@@ sv/dsw_out_if.sv @@
// Result channel: valid/ready handshake carrying the way count.
`timescale 1ns / 1ps
interface dsw_out_if;
  import dsw_pkg::*;
  logic              valid;
  logic              ready;
  logic [WAYS_W-1:0] ways;

  modport source (output valid, output ways, input ready);
  modport sink (input valid, input ways, output ready);
endinterface

@@ sv/dice_sum_way_counter.sv @@
// Top level of the dice sum way counter: sequencer, datapath and channel hookup.
`timescale 1ns / 1ps
// Counts the ordered outcomes of `dice` dice with `faces` faces each that add up to
// `target`, modulo 2^COUNT_WIDTH, returning the low 32 bits as one result per input
// transaction. Items take one at a time. When faces*dice <= target or dice >= target
// (or an operand exceeds MAX_FACES/MAX_DICE) the answer comes from a shortcut, through
// the product, check and shortcut steps to the result register. Otherwise a dynamic
// program builds one row per die in two ping-pong row banks, one sum per cycle
// through a sliding window fed by the bank's two read ports. The row banks need no
// clearing after reset. The result register lets the next transaction be accepted
// while a finished count still waits on the output.
module dice_sum_way_counter #(
  parameter int MAX_FACES   = dsw_pkg::MAX_FACES_DEF,
  parameter int MAX_DICE    = dsw_pkg::MAX_DICE_DEF,
  parameter int COUNT_WIDTH = dsw_pkg::COUNT_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  dsw_in_if.sink    in_ch,
  dsw_out_if.source out_ch
);
  import dsw_pkg::*;

  ctl_t  ctl;
  sts_t  sts;
  step_t step;

  // Program counter and control store
  dsw_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl),
    .step  (step)
  );

  // Everything the control words steer
  dsw_dp #(
    .MAX_FACES   (MAX_FACES),
    .MAX_DICE    (MAX_DICE),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sts       (sts),
    .in_valid  (in_ch.valid),
    .in_faces  (in_ch.faces),
    .in_dice   (in_ch.dice),
    .in_target (in_ch.target),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_ways  (out_ch.ways)
  );

  // Ready only while the program waits for work
  assign in_ch.ready = ctl.in_rdy;

  // The program never runs past its last step
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step <= S_SHORT)
    else $error("sequencer step outside the program");

  // An accepted transaction takes the sequencer out of the wait step
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("ready held after accepting a transaction");

  // A new result appears only after a result-load step
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(ctl.out_ld))
    else $error("result raised without a load step");
endmodule

@@ sv/dsw_ram.sv @@
// Row bank: one write port, two registered read ports.
`timescale 1ns / 1ps
module dsw_ram #(
  parameter int DEPTH = 4097,
  parameter int AW    = 13,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end
endmodule

@@ sv/dsw_seq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps
module dsw_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  dsw_pkg::sts_t  sts,
  output dsw_pkg::ctl_t  ctl,
  output dsw_pkg::step_t step
);
  import dsw_pkg::*;

  step_t  step_r;
  step_t  step_nxt;
  uword_t uw;
  logic   take;

  always_comb begin
    uw = ucode_rom(step_r);
    case (uw.cond)
      C_NONE:        take = 1'b0;
      C_IN_FIRE:     take = sts.in_valid;
      C_SHORT:       take = sts.short_cut;
      C_IDX_NE_TGT:  take = sts.idx_ne_tgt;
      C_ROWS_ZERO:   take = sts.rows_zero;
      C_IDX_NE_LAST: take = sts.idx_ne_last;
      C_OUT_BUSY:    take = sts.out_busy;
      default:       take = 1'b0;
    endcase
    step_nxt = take ? uw.jmp : uw.nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

  assign ctl  = uw.ctl;
  assign step = step_r;
endmodule

@@ sv/dsw_dp.sv @@
// Datapath: operand registers, shortcut checks, row banks, sliding window and result register.
`timescale 1ns / 1ps
module dsw_dp #(
  parameter int MAX_FACES   = dsw_pkg::MAX_FACES_DEF,
  parameter int MAX_DICE    = dsw_pkg::MAX_DICE_DEF,
  parameter int COUNT_WIDTH = dsw_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dsw_pkg::ctl_t                 ctl,
  output dsw_pkg::sts_t                 sts,
  input  logic                          in_valid,
  input  logic [dsw_pkg::FACES_W-1:0]   in_faces,
  input  logic [dsw_pkg::DICE_W-1:0]    in_dice,
  input  logic [dsw_pkg::TARGET_W-1:0]  in_target,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dsw_pkg::WAYS_W-1:0]    out_ways
);
  import dsw_pkg::*;

  localparam int SUM_DEPTH = MAX_FACES * MAX_DICE + 1;
  localparam int SUM_W     = $clog2(SUM_DEPTH);
  localparam int CW        = COUNT_WIDTH;

  logic [FACES_W-1:0]  faces_r;
  logic [DICE_W-1:0]   dice_r;
  logic [TARGET_W-1:0] target_r;
  logic [PROD_W-1:0]   prod_r;
  logic [SUM_W-1:0]    idx_r;
  logic [DICE_W-1:0]   rows_r;
  logic                bank_r;
  logic [CW-1:0]       win_r;
  logic [CW-1:0]       win_nxt;
  logic                v_d1_r;
  logic [SUM_W-1:0]    j_d1_r;
  logic                sub_d1_r;
  logic                za_d1_r;
  logic                zb_d1_r;
  logic                out_valid_r;
  logic [WAYS_W-1:0]   out_ways_r;

  logic [SUM_W-1:0]    tgt_idx;
  logic [SUM_W-1:0]    faces_idx;
  logic                prod_le;
  logic                dice_ge;
  logic                oversize;
  logic                short_val;
  logic                out_busy;

  logic                we;
  logic                wbank;
  logic [SUM_W-1:0]    waddr;
  logic [CW-1:0]       wdata;
  logic                re;
  logic [SUM_W-1:0]    raddr_a;
  logic [SUM_W-1:0]    raddr_b;
  logic [CW-1:0]       rd0_a, rd0_b, rd1_a, rd1_b;
  logic [CW-1:0]       rd_a, rd_b;
  logic [CW-1:0]       a_val, b_val;
  logic [63:0]         rd_ext;

  assign tgt_idx   = SUM_W'(target_r);
  assign faces_idx = SUM_W'(faces_r);

  // Shortcut tests on the latched operands
  assign prod_le  = PROD_W'(target_r) >= prod_r;
  assign dice_ge  = TARGET_W'(dice_r) >= target_r;
  assign oversize = (32'(faces_r) > 32'(MAX_FACES)) || (32'(dice_r) > 32'(MAX_DICE));
  assign short_val = prod_le ? (prod_r == PROD_W'(target_r)) :
                     dice_ge ? (TARGET_W'(dice_r) == target_r) : 1'b0;

  assign out_busy = out_valid_r && !out_ready;

  assign sts.in_valid    = in_valid;
  assign sts.short_cut   = prod_le || dice_ge || oversize;
  assign sts.idx_ne_tgt  = idx_r != tgt_idx;
  assign sts.idx_ne_last = idx_r != (tgt_idx - SUM_W'(1));
  assign sts.rows_zero   = rows_r == '0;
  assign sts.out_busy    = out_busy;

  // Operands
  always_ff @(posedge clk) begin
    if (in_valid && ctl.in_rdy) begin
      faces_r  <= in_faces;
      dice_r   <= in_dice;
      target_r <= in_target;
    end
    if (ctl.prod_ld) begin
      prod_r <= PROD_W'(faces_r) * PROD_W'(dice_r);
    end
  end

  // Sum index and remaining-row count
  always_ff @(posedge clk) begin
    if (ctl.idx_one) begin
      idx_r <= SUM_W'(1);
    end else if (ctl.idx_clr) begin
      idx_r <= '0;
    end else if (ctl.idx_inc) begin
      idx_r <= idx_r + SUM_W'(1);
    end
    if (ctl.rows_ld) begin
      rows_r <= dice_r - DICE_W'(1);
    end else if (ctl.rows_dec) begin
      rows_r <= rows_r - DICE_W'(1);
    end
  end

  // Bank holding the finished row; flip once the new row is written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r <= 1'b0;
    end else if (ctl.bank_flip) begin
      bank_r <= ~bank_r;
    end
  end

  // Read issue stage bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_d1_r <= 1'b0;
    end else begin
      v_d1_r <= ctl.rd_cell;
    end
  end

  always_ff @(posedge clk) begin
    j_d1_r   <= idx_r;
    sub_d1_r <= idx_r >= faces_idx;
    za_d1_r  <= idx_r == '0;
    zb_d1_r  <= idx_r == faces_idx;
  end

  assign re      = ctl.rd_cell || ctl.rd_tgt;
  assign raddr_a = ctl.rd_tgt ? tgt_idx : idx_r;
  assign raddr_b = idx_r - faces_idx;

  assign rd_a = bank_r ? rd1_a : rd0_a;
  assign rd_b = bank_r ? rd1_b : rd0_b;

  // Entry zero of every row is zero and is never stored
  assign a_val   = za_d1_r ? '0 : rd_a;
  assign b_val   = (sub_d1_r && !zb_d1_r) ? rd_b : '0;
  assign win_nxt = win_r + a_val - b_val;

  always_ff @(posedge clk) begin
    if (ctl.win_clr) begin
      win_r <= '0;
    end else if (v_d1_r) begin
      win_r <= win_nxt;
    end
  end

  // Write port: first row during init, window sums during a row
  assign we    = ctl.init_wr || v_d1_r;
  assign wbank = ctl.init_wr ? bank_r : ~bank_r;
  assign waddr = ctl.init_wr ? idx_r : (j_d1_r + SUM_W'(1));
  assign wdata = ctl.init_wr ? ((idx_r <= faces_idx) ? CW'(1) : '0) : win_nxt;

  dsw_ram #(
    .DEPTH (SUM_DEPTH),
    .AW    (SUM_W),
    .DW    (CW)
  ) u_bank0 (
    .clk     (clk),
    .we      (we && !wbank),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd0_a),
    .rdata_b (rd0_b)
  );

  dsw_ram #(
    .DEPTH (SUM_DEPTH),
    .AW    (SUM_W),
    .DW    (CW)
  ) u_bank1 (
    .clk     (clk),
    .we      (we && wbank),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd1_a),
    .rdata_b (rd1_b)
  );

  assign rd_ext = 64'(rd_a);

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_ld && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_ld && !out_busy) begin
      out_ways_r <= ctl.out_src_mem ? rd_ext[WAYS_W-1:0] : WAYS_W'(short_val);
    end
  end

  assign out_valid = out_valid_r;
  assign out_ways  = out_ways_r;
endmodule

@@ test/tb_dice_sum_way_counter.sv @@
// Self-checking testbench for the dice sum way counter: directed table, then random rolls.
`timescale 1ns / 1ps
module tb_dice_sum_way_counter;
  import dsw_pkg::*;

  // Longest stretch without any transaction before the run is declared hung.
  // The slowest legal item has 64 dice and target 4095.
  localparam int STALL_LIMIT  = 1_000_000;
  // Long enough to outlast two of the costliest random rolls, so the block fills.
  localparam int HOLD_CYCLES  = 50_000;
  localparam int TAIL_CYCLES  = 20;
  localparam int PHASE_ROLLS  = 25;
  localparam int REPORT_LIMIT = 10;
  localparam int DIR_ROWS     = 25;
  // Cap on dice * target for noise rolls, so a stray roll cannot eat the run time.
  localparam int NOISE_COST   = 20000;

  // One stimulus row: the operands, plus an optional hand-typed answer.
  typedef struct packed {
    logic [FACES_W-1:0]  faces;
    logic [DICE_W-1:0]   dice;
    logic [TARGET_W-1:0] target;
    logic                typed;
    logic [WAYS_W-1:0]   ways;
  } roll_t;

  // Directed table. Rows with typed set carry their answer; the rest go
  // through the predictor.
  localparam roll_t DIRECTED [DIR_ROWS] = '{
    '{7'd1,   7'd0,   13'd0,    1'b1, 32'd1},  // zero dice, target 0
    '{7'd6,   7'd0,   13'd4,    1'b1, 32'd0},  // zero dice, nonzero target
    '{7'd0,   7'd5,   13'd0,    1'b1, 32'd1},  // zero faces, target 0
    '{7'd0,   7'd5,   13'd3,    1'b1, 32'd0},  // zero faces, nonzero target
    '{7'd0,   7'd0,   13'd0,    1'b1, 32'd1},  // all zero
    '{7'd1,   7'd1,   13'd1,    1'b1, 32'd1},  // smallest real roll
    '{7'd6,   7'd2,   13'd12,   1'b1, 32'd1},  // target equals faces * dice
    '{7'd6,   7'd2,   13'd13,   1'b1, 32'd0},  // target above faces * dice
    '{7'd6,   7'd3,   13'd3,    1'b1, 32'd1},  // target equals dice
    '{7'd6,   7'd4,   13'd2,    1'b1, 32'd0},  // target below dice
    '{7'd2,   7'd1,   13'd1,    1'b1, 32'd1},  // single die, dice shortcut
    '{7'd127, 7'd1,   13'd0,    1'b1, 32'd0},  // widest faces, target 0
    '{7'd64,  7'd1,   13'd8191, 1'b1, 32'd0},  // widest target
    '{7'd127, 7'd127, 13'd8191, 1'b1, 32'd0},  // all fields at top, oversized
    '{7'd100, 7'd2,   13'd50,   1'b1, 32'd0},  // oversized faces
    '{7'd2,   7'd100, 13'd150,  1'b1, 32'd0},  // oversized dice
    '{7'd65,  7'd64,  13'd4100, 1'b1, 32'd0},  // faces one past the rows
    '{7'd1,   7'd64,  13'd63,   1'b1, 32'd0},  // dice above target
    '{7'd64,  7'd64,  13'd4096, 1'b1, 32'd1},  // largest exact product
    '{7'd6,   7'd2,   13'd7,    1'b1, 32'd6},  // two dice, most likely sum
    '{7'd3,   7'd127, 13'd4096, 1'b1, 32'd0},  // product below a large target
    '{7'd64,  7'd2,   13'd65,   1'b0, 32'd0},
    '{7'd2,   7'd64,  13'd100,  1'b0, 32'd0},  // count wraps past 32 bits
    '{7'd64,  7'd64,  13'd4095, 1'b0, 32'd0},  // deepest table
    '{7'd64,  7'd64,  13'd2080, 1'b0, 32'd0}   // wide table, heavy wrap
  };

  logic clk;
  logic rst_n;

  dsw_in_if  in_ch ();
  dsw_out_if out_ch ();

  dice_sum_way_counter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Rolls queued by the sender, popped when the block takes them.
  roll_t             pending_rolls [$];
  // Way counts still owed by the block, oldest first.
  logic [WAYS_W-1:0] owed_ways [$];

  // Rows of the predictor's table; only entries up to the target are touched.
  logic [WAYS_W-1:0] die_row  [0:MAX_FACES_DEF*MAX_DICE_DEF];
  logic [WAYS_W-1:0] next_row [0:MAX_FACES_DEF*MAX_DICE_DEF];

  int failures;
  int quiet_cycles;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_reqs;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count ordered outcomes adding up to the target, modulo 2^32.
  function automatic logic [WAYS_W-1:0] predict_ways(input logic [FACES_W-1:0] f_in,
                                                     input logic [DICE_W-1:0] d_in,
                                                     input logic [TARGET_W-1:0] t_in);
    int unsigned       nf, nd, nt, prod, die, s;
    logic [WAYS_W-1:0] win;
    nf   = f_in;
    nd   = d_in;
    nt   = t_in;
    prod = nf * nd;
    // Shortcuts: sum out of reach or pinned to its bound.
    if (prod <= nt) return (prod == nt) ? 32'd1 : 32'd0;
    if (nd >= nt) return (nd == nt) ? 32'd1 : 32'd0;
    // Operands beyond the table size answer zero.
    if (nf > MAX_FACES_DEF || nd > MAX_DICE_DEF) return '0;
    for (s = 0; s <= nt; s++) die_row[s] = (s >= 1 && s <= nf) ? 32'd1 : 32'd0;
    for (die = 2; die <= nd; die++) begin
      // Slide a window of width faces over the previous row.
      win         = '0;
      next_row[0] = '0;
      for (s = 1; s <= nt; s++) begin
        win = win + die_row[s-1];
        if (s - 1 >= nf) win = win - die_row[s-1-nf];
        next_row[s] = win;
      end
      for (s = 0; s <= nt; s++) die_row[s] = next_row[s];
    end
    return die_row[nt];
  endfunction

  // Offer one roll after a random gap; return at the edge that accepts it.
  task automatic send_roll(input roll_t r);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pending_rolls.push_back(r);
    in_ch.valid  <= 1'b1;
    in_ch.faces  <= r.faces;
    in_ch.dice   <= r.dice;
    in_ch.target <= r.target;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and hold off until every owed count has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (owed_ways.size() != 0 || pending_rolls.size() != 0) @(posedge clk);
  endtask

  // Scoreboard: check the result transaction first, then record the input one.
  // Both live in one process so their order within an edge is fixed.
  always @(posedge clk) begin : scoreboard
    roll_t             r;
    logic [WAYS_W-1:0] want;
    bit                moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (owed_ways.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("[%0t] unexpected result: ways=%0d", $realtime, out_ch.ways);
        end else begin
          want = owed_ways.pop_front();
          if (out_ch.ways !== want) begin
            failures++;
            if (failures <= REPORT_LIMIT)
              $display("[%0t] ways mismatch: expected %0d, got %0d",
                       $realtime, want, out_ch.ways);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        r     = pending_rolls.pop_front();
        // Trust the typed answer where the row carries one.
        want  = r.typed ? r.ways : predict_ways(in_ch.faces, in_ch.dice, in_ch.target);
        owed_ways.push_back(want);
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
  end

  // Watchdog: give up when no transaction moves for too long.
  initial begin : watchdog
    @(posedge clk);
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request so the
  // block fills up and stalls its input.
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    roll_t       r;
    int unsigned f, d, t, pick;
    int          phase, n;
    tx_idle_pct  = 27;
    rx_idle_pct  = 80;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.faces  = '0;
    in_ch.dice   = '0;
    in_ch.target = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, under the first idling mix.
    for (n = 0; n < DIR_ROWS; n++) send_roll(DIRECTED[n]);
    wait_drained();

    // Random rolls in three idling mixes: sender light / receiver heavy,
    // swapped, then none. Each phase ends with a full drain.
    for (phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 80 : 0;
      rx_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 27 : 0;
      for (n = 0; n < PHASE_ROLLS; n++) begin
        // Start the long receiver hold-off while the sender keeps offering.
        if (phase == 2 && n == 8) hold_reqs++;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          // Small table: the common, cheap case that exercises the row loop.
          f = $urandom_range(2, 8);
          d = $urandom_range(2, 8);
          t = $urandom_range(d + 1, f * d - 1);
        end else if (pick < 72) begin
          // Wider faces, few dice.
          f = $urandom_range(9, MAX_FACES_DEF);
          d = $urandom_range(2, 12);
          t = $urandom_range(d + 1, f * d - 1);
        end else if (pick < 78) begin
          // Land on or next to one of the shortcut boundaries.
          f = $urandom_range(1, MAX_FACES_DEF);
          d = $urandom_range(0, MAX_DICE_DEF);
          case ($urandom_range(0, 3))
            0: t = f * d;
            1: t = f * d + 1;
            2: t = d;
            default: t = (d == 0) ? 0 : d - 1;
          endcase
        end else begin
          // Noise over the whole field range; push costly tables out of range.
          f = $urandom_range(0, 127);
          d = $urandom_range(0, 127);
          t = $urandom_range(0, 8191);
          if (f <= MAX_FACES_DEF && d <= MAX_DICE_DEF && t < f * d && d < t &&
              d * t > NOISE_COST)
            f = f | 65;
        end
        r        = '0;
        r.faces  = f[FACES_W-1:0];
        r.dice   = d[DICE_W-1:0];
        r.target = t[TARGET_W-1:0];
        send_roll(r);
      end
      wait_drained();
    end

    // Leave room for any stray result, then report.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && owed_ways.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
